// ===== hw/rtl/cmta_pkg.sv =====
// ============================================================================
// cmta_pkg
// Shared types, constants and helpers of the cursor mask to ARGB unit.
// ============================================================================
package cmta_pkg;

   localparam int MAX_WIDTH    = 64;
   localparam int PIX_PER_BYTE = 8;
   localparam int COLS         = MAX_WIDTH / PIX_PER_BYTE;
   localparam int COL_W        = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int CNT_W        = COL_W + 1;
   localparam int ROW_BYTES_W  = 4;
   localparam int SAT_W        = (CNT_W > ROW_BYTES_W) ? CNT_W : ROW_BYTES_W;
   localparam int CODE_W       = 2;
   localparam int MEM_W        = PIX_PER_BYTE * CODE_W;
   localparam int MODE_W       = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 4;
   localparam int ARGB_W       = 32;
   localparam int COUNT_W      = 4;

   typedef logic [CODE_W-1:0] code_type;

   localparam code_type CODE_BLACK   = 2'd0;
   localparam code_type CODE_CLEAR   = 2'd1;
   localparam code_type CODE_WHITE   = 2'd2;
   localparam code_type CODE_INVERSE = 2'd3;

   localparam logic [MODE_W-1:0] MODE_MONO   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COLOR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MASKED = 2'd2;

   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_BYTES = 1'd1;

   localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 4'd4;

   localparam logic [ARGB_W-1:0] ARGB_BLACK = 32'hFF00_0000;
   localparam logic [ARGB_W-1:0] ARGB_WHITE = 32'hFFFF_FFFF;
   localparam logic [ARGB_W-1:0] ARGB_CLEAR = 32'h0000_0000;

   localparam logic [COUNT_W-1:0] COUNT_MONO  = 4'd8;
   localparam logic [COUNT_W-1:0] COUNT_COLOR = 4'd1;

   typedef struct packed {
      logic              op;
      logic [7:0]        and_byte;
      logic [7:0]        xor_byte;
      logic [ARGB_W-1:0] color_pixel;
   } req_beat_type;

   typedef struct packed {
      logic [ARGB_W-1:0]  pixel_0;
      logic [ARGB_W-1:0]  pixel_1;
      logic [ARGB_W-1:0]  pixel_2;
      logic [ARGB_W-1:0]  pixel_3;
      logic [ARGB_W-1:0]  pixel_4;
      logic [ARGB_W-1:0]  pixel_5;
      logic [ARGB_W-1:0]  pixel_6;
      logic [ARGB_W-1:0]  pixel_7;
      logic [COUNT_W-1:0] valid_pixels;
   } rsp_beat_type;

   // item in the read/modify stage
   typedef struct packed {
      logic              valid;
      logic              mono;
      logic              flush;
      logic              had_above;
      logic              color_clear;
      logic [COL_W-1:0]  col;
      logic [7:0]        and_byte;
      logic [7:0]        xor_byte;
      logic [ARGB_W-1:0] color_pixel;
   } stage_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [MEM_W-1:0] data;
   } mem_wr_type;

   function automatic logic [ARGB_W-1:0] code_to_argb(input code_type code);
      logic [ARGB_W-1:0] argb;
      case (code)
         CODE_BLACK: argb = ARGB_BLACK;
         CODE_CLEAR: argb = ARGB_CLEAR;
         default:    argb = ARGB_WHITE;
      endcase
      return argb;
   endfunction

endpackage

// ===== hw/rtl/cursor_mask_to_argb_unit.sv =====
// ============================================================================
// cursor_mask_to_argb_unit
// Expands monochrome cursor AND/XOR masks to ARGB pixel groups through a
// one-row line store; color cursors pass through or are alpha-masked.
// ============================================================================
// One request beat is taken every cycle while the result side keeps up.
// Each beat passes through launch (line store read issued), the
// read/modify stage (store write-back) and lands in the result register.
// The line store is one synchronous RAM, one row per mask byte column,
// read and written once a cycle while the pipeline advances; a row written
// while the next beat reads it is forwarded. In monochrome mode the first
// row of a cursor returns nothing, each later data beat returns the
// finished eight pixels of the row above, and flush beats drain the last
// row. Color modes return one pixel per data beat. The store needs no
// clearing after reset. Write the CSRs only while idle.
module cursor_mask_to_argb_unit
   import cmta_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_beat_type           req_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_beat_type           rsp_beat,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic             advance;
   logic [COL_W-1:0] rd_col;
   stage_type        stage;
   mem_wr_type       wr;
   logic [MEM_W-1:0] rd_row;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   cmta_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_beat  (req_beat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rd_col    (rd_col),
      .stage     (stage)
   );

   cmta_line_mem u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rd_col  (rd_col),
      .wr      (wr),
      .rd_row  (rd_row)
   );

   cmta_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .stage     (stage),
      .rd_row    (rd_row),
      .wr        (wr),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat)
   );

endmodule

// ===== hw/rtl/cmta_sequencer.sv =====
// ============================================================================
// cmta_sequencer
// Configuration registers, row position tracking and the stage register
// that carries each launched beat into the line store stage.
// ============================================================================
module cmta_sequencer
   import cmta_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   req_valid,
   input  req_beat_type           req_beat,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic [COL_W-1:0]       rd_col,
   output stage_type              stage
);

   logic [MODE_W-1:0]      mode_ff;
   logic [ROW_BYTES_W-1:0] row_bytes_ff;
   logic [COL_W-1:0]       byte_column_ff, byte_column_in;
   logic                   first_row_ff, first_row_in;
   stage_type              stage_ff, stage_in;

   logic             mono;
   logic             is_flush;
   logic             accept;
   logic             launch;
   logic             wrap;
   logic [SAT_W-1:0] rb_eff;
   logic [SAT_W-1:0] col_next;

   always_comb begin
      mono     = !(mode_ff == MODE_COLOR || mode_ff == MODE_MASKED);
      is_flush = (req_beat.op == OP_FLUSH);
      accept   = req_valid && advance;
      launch   = accept && (mono ? (!is_flush || !first_row_ff) : !is_flush);

      rb_eff = SAT_W'(row_bytes_ff);
      if (rb_eff == '0) begin
         rb_eff = SAT_W'(1);
      end else if (rb_eff > SAT_W'(COLS)) begin
         rb_eff = SAT_W'(COLS);
      end
      col_next = SAT_W'(byte_column_ff) + SAT_W'(1);
      wrap     = (col_next >= rb_eff);

      byte_column_in = byte_column_ff;
      first_row_in   = first_row_ff;
      if (launch && mono) begin
         if (wrap) begin
            byte_column_in = '0;
            first_row_in   = is_flush;
         end else begin
            byte_column_in = col_next[COL_W-1:0];
         end
      end

      stage_in.valid       = launch;
      stage_in.mono        = mono;
      stage_in.flush       = is_flush;
      stage_in.had_above   = !first_row_ff;
      stage_in.color_clear = (mode_ff == MODE_MASKED) && (req_beat.color_pixel[31:24] != 8'd0);
      stage_in.col         = byte_column_ff;
      stage_in.and_byte    = req_beat.and_byte;
      stage_in.xor_byte    = req_beat.xor_byte;
      stage_in.color_pixel = req_beat.color_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_MONO;
         row_bytes_ff   <= ROW_BYTES_RESET;
         byte_column_ff <= '0;
         first_row_ff   <= 1'b1;
         stage_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_MODE:      mode_ff      <= csr_wdata[MODE_W-1:0];
               REG_ROW_BYTES: row_bytes_ff <= csr_wdata[ROW_BYTES_W-1:0];
               default: ;
            endcase
         end
         byte_column_ff <= byte_column_in;
         first_row_ff   <= first_row_in;
         if (advance) begin
            stage_ff <= stage_in;
         end
      end
   end

   assign rd_col = byte_column_ff;
   assign stage  = stage_ff;

`ifndef ASSERT_OFF
   a_flush_end_rearms: assert property (@(posedge clock) disable iff (reset)
      (launch && mono && is_flush && wrap) |=> (first_row_ff && byte_column_ff == '0))
      else $error("last flush of a cursor did not rearm the first row");
`endif

endmodule

// ===== hw/rtl/cmta_line_mem.sv =====
// ============================================================================
// cmta_line_mem
// One-row line store: one row of pixel codes per byte column, one read and
// one write a cycle while advance is high, registered read with write-to-read forwarding.
// ============================================================================
module cmta_line_mem
   import cmta_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [COL_W-1:0] rd_col,
   input  mem_wr_type       wr,
   output logic [MEM_W-1:0] rd_row
);

   logic [MEM_W-1:0] mem [COLS];
   logic [MEM_W-1:0] rd_data_ff;
   logic [MEM_W-1:0] fwd_data_ff;
   logic             fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (advance) begin
         rd_data_ff  <= mem[rd_col];
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (advance) begin
         fwd_hit_ff <= wr.en && (wr.addr == rd_col);
      end
   end

   assign rd_row = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

`ifndef ASSERT_OFF
   a_same_row_forwarded: assert property (@(posedge clock) disable iff (reset)
      (advance && wr.en && wr.addr == rd_col) |=> fwd_hit_ff)
      else $error("read of a row being written was not forwarded");
`endif

endmodule

// ===== hw/rtl/cmta_emit.sv =====
// ============================================================================
// cmta_emit
// Mask decode, inverse outline, line store write-back and the result
// register.
// ============================================================================
module cmta_emit
   import cmta_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  stage_type        stage,
   input  logic [MEM_W-1:0] rd_row,
   output mem_wr_type       wr,
   output logic             rsp_valid,
   output rsp_beat_type     rsp_beat
);

   // set when pixel 0 of the next column is inverse, so a clear pixel 7 of this row reads black
   logic [COLS-1:0] left_black_ff, left_black_in;
   logic            rsp_valid_ff;
   rsp_beat_type    rsp_beat_ff;
   rsp_beat_type    rsp_in;

   code_type   code   [PIX_PER_BYTE];
   code_type   stored [PIX_PER_BYTE];
   code_type   above  [PIX_PER_BYTE];
   code_type   cur    [PIX_PER_BYTE];
   logic       mono_data;
   logic       emit_ok;
   logic [COL_W-1:0] col_prev;

   always_comb begin
      mono_data = stage.valid && stage.mono && !stage.flush;
      col_prev  = stage.col - COL_W'(1);

      for (int k = 0; k < PIX_PER_BYTE; k++) begin
         code[k]   = {stage.xor_byte[PIX_PER_BYTE-1-k], stage.and_byte[PIX_PER_BYTE-1-k]};
         stored[k] = rd_row[k*CODE_W +: CODE_W];
      end
      if (stored[PIX_PER_BYTE-1] == CODE_CLEAR && left_black_ff[stage.col]) begin
         stored[PIX_PER_BYTE-1] = CODE_BLACK;
      end

      for (int k = 0; k < PIX_PER_BYTE; k++) begin
         above[k] = stored[k];
         if (mono_data && stage.had_above && code[k] == CODE_INVERSE
             && stored[k] == CODE_CLEAR) begin
            above[k] = CODE_BLACK;
         end
      end

      for (int k = 0; k < PIX_PER_BYTE - 1; k++) begin
         if (code[k] == CODE_INVERSE) begin
            cur[k] = CODE_WHITE;
         end else if (code[k] == CODE_CLEAR && code[k+1] == CODE_INVERSE) begin
            cur[k] = CODE_BLACK;
         end else begin
            cur[k] = code[k];
         end
      end
      cur[PIX_PER_BYTE-1] = (code[PIX_PER_BYTE-1] == CODE_INVERSE) ? CODE_WHITE
                                                                   : code[PIX_PER_BYTE-1];

      wr.en   = advance && mono_data;
      wr.addr = stage.col;
      for (int k = 0; k < PIX_PER_BYTE; k++) begin
         wr.data[k*CODE_W +: CODE_W] = cur[k];
      end

      left_black_in = left_black_ff;
      if (wr.en) begin
         left_black_in[stage.col] = 1'b0;
         if (stage.col != '0 && code[0] == CODE_INVERSE) begin
            left_black_in[col_prev] = 1'b1;
         end
      end

      emit_ok = stage.valid && (!stage.mono || stage.flush || stage.had_above);

      if (stage.mono) begin
         rsp_in.pixel_0      = code_to_argb(above[0]);
         rsp_in.pixel_1      = code_to_argb(above[1]);
         rsp_in.pixel_2      = code_to_argb(above[2]);
         rsp_in.pixel_3      = code_to_argb(above[3]);
         rsp_in.pixel_4      = code_to_argb(above[4]);
         rsp_in.pixel_5      = code_to_argb(above[5]);
         rsp_in.pixel_6      = code_to_argb(above[6]);
         rsp_in.pixel_7      = code_to_argb(above[7]);
         rsp_in.valid_pixels = COUNT_MONO;
      end else begin
         rsp_in.pixel_0      = stage.color_clear ? ARGB_CLEAR : stage.color_pixel;
         rsp_in.pixel_1      = ARGB_CLEAR;
         rsp_in.pixel_2      = ARGB_CLEAR;
         rsp_in.pixel_3      = ARGB_CLEAR;
         rsp_in.pixel_4      = ARGB_CLEAR;
         rsp_in.pixel_5      = ARGB_CLEAR;
         rsp_in.pixel_6      = ARGB_CLEAR;
         rsp_in.pixel_7      = ARGB_CLEAR;
         rsp_in.valid_pixels = COUNT_COLOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_black_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         left_black_ff <= left_black_in;
         if (advance) begin
            rsp_valid_ff <= emit_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_beat_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

`ifndef ASSERT_OFF
   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_beat_ff.valid_pixels == COUNT_MONO
                        || rsp_beat_ff.valid_pixels == COUNT_COLOR))
      else $error("result beat with a bad pixel count");

   a_flush_has_row: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && stage.flush) |-> (stage.mono && stage.had_above))
      else $error("flush launched without a held row");
`endif

endmodule

// ===== dv/tb.sv =====
// ============================================================================
// tb
// Testbench of the cursor mask to ARGB unit. A scoreboard object mirrors the
// line store, column and first-row state and the CSRs, expands each
// accepted request beat into its expected pixel group, if it gives one,
// and checks each result beat field by field. Directed beats cover the
// mask codes, inverse outlines, flush and ignored flush, CSR extremes and
// a mid-row shrink of the row width. Random cursors, broken rows and color
// beats follow, with random idle and stall bursts on both channels.
// ============================================================================
module tb;
   import cmta_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int RAND_BEATS  = 1650;
   localparam int CALM_TAIL   = 200;
   localparam int SETTLE      = 6;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   class argb_scoreboard;
      code_type               line_codes [MAX_WIDTH];
      logic [ARGB_W-1:0]      argb_of [4];
      int                     column;
      bit                     first_row;
      logic [MODE_W-1:0]      mode;
      logic [ROW_BYTES_W-1:0] row_bytes;
      bit [COLS-1:0]          col_written;
      rsp_beat_type           pending_groups [$];
      int                     errors;

      function new();
         argb_of     = '{ARGB_BLACK, ARGB_CLEAR, ARGB_WHITE, ARGB_WHITE};
         column      = 0;
         first_row   = 1'b1;
         mode        = MODE_MONO;
         row_bytes   = ROW_BYTES_RESET;
         col_written = '0;
         errors      = 0;
      endfunction

      function int clamp_width(logic [ROW_BYTES_W-1:0] raw);
         int rb;
         rb = int'(raw);
         if (rb == 0) rb = 1;
         if (rb > COLS) rb = COLS;
         return rb;
      endfunction

      // widening must never expose a store column that was never written
      function bit width_allowed(logic [ROW_BYTES_W-1:0] raw);
         if (first_row) return 1'b1;
         for (int c = 0; c < clamp_width(raw); c++)
            if (!col_written[c]) return 1'b0;
         return 1'b1;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            REG_MODE:      mode = d[MODE_W-1:0];
            REG_ROW_BYTES: row_bytes = d[ROW_BYTES_W-1:0];
            default: ;
         endcase
      endfunction

      function rsp_beat_type mono_group(input code_type codes [8]);
         logic [8*ARGB_W-1:0] px;
         for (int k = 0; k < 8; k++) px[ARGB_W*(7-k) +: ARGB_W] = argb_of[codes[k]];
         return {px, COUNT_MONO};
      endfunction

      // returns 0 when the beat is ignored by the block
      function bit expand_beat(req_beat_type b);
         code_type     above [8];
         code_type     cur [8];
         code_type     code;
         rsp_beat_type g;
         int           col;
         int           x;
         bit           had_above;
         col = column;
         if (mode == MODE_COLOR || mode == MODE_MASKED) begin
            if (b.op == OP_FLUSH) return 1'b0;
            g = '0;
            g.pixel_0 = (mode == MODE_MASKED && b.color_pixel[31:24] != 8'd0) ?
                        ARGB_CLEAR : b.color_pixel;
            g.valid_pixels = COUNT_COLOR;
            pending_groups.push_back(g);
            return 1'b1;
         end
         for (int k = 0; k < 8; k++) above[k] = line_codes[col*8 + k];
         if (b.op == OP_FLUSH) begin
            if (first_row) return 1'b0;
            pending_groups.push_back(mono_group(above));
            column = col + 1;
            if (column >= clamp_width(row_bytes)) begin
               column    = 0;
               first_row = 1'b1;
            end
            return 1'b1;
         end
         for (int k = 0; k < 8; k++) begin
            code = {b.xor_byte[7-k], b.and_byte[7-k]};
            x    = col*8 + k;
            if (code == CODE_INVERSE) begin
               if (!first_row && above[k] == CODE_CLEAR) above[k] = CODE_BLACK;
               if (x != 0) begin
                  if (k == 0) begin
                     if (line_codes[x-1] == CODE_CLEAR) line_codes[x-1] = CODE_BLACK;
                  end else if (cur[k-1] == CODE_CLEAR) begin
                     cur[k-1] = CODE_BLACK;
                  end
               end
               cur[k] = CODE_WHITE;
            end else begin
               cur[k] = code;
            end
         end
         for (int k = 0; k < 8; k++) line_codes[col*8 + k] = cur[k];
         col_written[col] = 1'b1;
         had_above = !first_row;
         column = col + 1;
         if (column >= clamp_width(row_bytes)) begin
            column    = 0;
            first_row = 1'b0;
         end
         if (had_above) pending_groups.push_back(mono_group(above));
         return 1'b1;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_group(rsp_beat_type got);
         rsp_beat_type                    want;
         logic [$bits(rsp_beat_type)-1:0] gv;
         logic [$bits(rsp_beat_type)-1:0] wv;
         if (pending_groups.size() == 0) begin
            report($sformatf("group %h with none expected", got));
            return;
         end
         want = pending_groups.pop_front();
         gv   = got;
         wv   = want;
         for (int k = 0; k < 8; k++)
            if (gv[COUNT_W + ARGB_W*(7-k) +: ARGB_W] !== wv[COUNT_W + ARGB_W*(7-k) +: ARGB_W])
               report($sformatf("pixel_%0d got %h expected %h", k,
                                gv[COUNT_W + ARGB_W*(7-k) +: ARGB_W],
                                wv[COUNT_W + ARGB_W*(7-k) +: ARGB_W]));
         if (got.valid_pixels !== want.valid_pixels)
            report($sformatf("valid_pixels got %0d expected %0d",
                             got.valid_pixels, want.valid_pixels));
      endtask
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_beat_type           req_beat  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_beat_type           rsp_beat;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bit gaps_on    = 1'b1;
   bit stalls_on  = 1'b1;
   bit hold_kick  = 1'b0;
   bit hold_seen  = 1'b0;
   int hold_left  = 0;
   int burst_left = 0;
   int quiet      = 0;
   int beats_used = 0;

   argb_scoreboard sb;

   always #6 clock = ~clock;

   cursor_mask_to_argb_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // result side: check accepted beats, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_group(rsp_beat);
      if (hold_kick != hold_seen) begin
         hold_seen = hold_kick;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic push(input logic op, input logic [7:0] a, input logic [7:0] x,
                       input logic [ARGB_W-1:0] pix);
      req_beat_type b;
      b.op          = op;
      b.and_byte    = a;
      b.xor_byte    = x;
      b.color_pixel = pix;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sb.expand_beat(b)) beats_used++;
   endtask

   task automatic push_masks(input logic op);
      logic [7:0] a;
      logic [7:0] x;
      a = 8'($urandom);
      x = 8'($urandom);
      case ($urandom_range(0, 4))
         0: begin
            a = 8'($urandom | $urandom);
            x = a & 8'($urandom | $urandom);
         end
         1: begin
            a = 8'hFF;
            x = 8'h01 << $urandom_range(0, 7);
         end
         2: begin
            a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            x = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      push(op, a, x, $urandom);
   endtask

   function automatic logic [ARGB_W-1:0] pick_pixel();
      case ($urandom_range(0, 4))
         0: return $urandom & 32'h00FF_FFFF;
         1: return ($urandom_range(0, 1) ? ARGB_WHITE : ARGB_CLEAR);
         2: return ($urandom_range(0, 1) ? 32'h0100_0000 : 32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_groups.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input logic [MODE_W-1:0] m, input logic [ROW_BYTES_W-1:0] rb);
      csr_we    <= 1'b1;
      csr_index <= REG_MODE;
      csr_wdata <= CSR_DATA_W'(m);
      @(posedge clock);
      sb.write_reg(REG_MODE, CSR_DATA_W'(m));
      csr_index <= REG_ROW_BYTES;
      csr_wdata <= rb;
      @(posedge clock);
      sb.write_reg(REG_ROW_BYTES, rb);
      csr_we <= 1'b0;
   endtask

   task automatic mono_phase(input int n);
      int done_at;
      int eff;
      done_at = beats_used + n;
      while (beats_used < done_at) begin
         eff = sb.clamp_width(sb.row_bytes);
         case ($urandom_range(0, 9))
            7, 8: repeat ($urandom_range(1, 2*eff))
                     push_masks($urandom_range(0, 3) == 0 ? OP_FLUSH : OP_DATA);
            9: repeat ($urandom_range(1, 3)) push_masks(OP_FLUSH);
            default: begin
               // finish whatever is open, then one whole cursor
               while (!sb.first_row || sb.column != 0)
                  push_masks(sb.first_row ? OP_DATA : OP_FLUSH);
               repeat ($urandom_range(1, 5) * eff) push_masks(OP_DATA);
               repeat (eff) push_masks(OP_FLUSH);
            end
         endcase
      end
   endtask

   task automatic color_phase(input int n);
      repeat (n) push($urandom_range(0, 6) == 0 ? OP_FLUSH : OP_DATA, 8'($urandom),
                      8'($urandom), pick_pixel());
   endtask

   initial begin
      logic [MODE_W-1:0]      m;
      logic [ROW_BYTES_W-1:0] rb;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      configure(MODE_MONO, 4'd1);
      push(OP_DATA, 8'hFF, 8'h00, 32'h0);
      push(OP_DATA, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      push(OP_DATA, 8'hFF, 8'h55, 32'h0);
      push(OP_FLUSH, 8'h00, 8'h00, 32'h0);
      push(OP_FLUSH, 8'hFF, 8'hFF, 32'h0);
      settle();
      configure(MODE_MONO, 4'd2);
      push(OP_DATA, 8'hFF, 8'h00, 32'h0);
      push(OP_DATA, 8'h80, 8'h80, 32'h0);
      push(OP_DATA, 8'h00, 8'h00, 32'h0);
      push(OP_DATA, 8'hFF, 8'hFF, 32'h0);
      push(OP_FLUSH, 8'h00, 8'h00, 32'h0);
      push(OP_FLUSH, 8'h00, 8'h00, 32'h0);
      settle();
      configure(MODE_SPARE, 4'd4);
      repeat (3) push(OP_DATA, 8'hFF, 8'h00, 32'h0);
      settle();
      // width shrinks under the column: the beat lands there and the row wraps
      configure(MODE_SPARE, 4'd0);
      push(OP_DATA, 8'h5A, 8'hA5, 32'h0);
      push(OP_DATA, 8'h00, 8'hFF, 32'h0);
      push(OP_FLUSH, 8'h00, 8'h00, 32'h0);
      settle();
      configure(MODE_COLOR, 4'd15);
      push(OP_DATA, 8'h00, 8'h00, 32'hFFFF_FFFF);
      push(OP_DATA, 8'hFF, 8'hFF, 32'h0000_0000);
      push(OP_FLUSH, 8'h00, 8'h00, 32'h1234_5678);
      settle();
      configure(MODE_MASKED, 4'd8);
      push(OP_DATA, 8'h00, 8'h00, 32'h0100_0000);
      push(OP_DATA, 8'h00, 8'h00, 32'h00FF_FFFF);
      push(OP_DATA, 8'h00, 8'h00, 32'h8000_0000);
      settle();

      // long result hold-off while the sender keeps offering beats
      configure(MODE_COLOR, 4'd1);
      hold_kick <= ~hold_kick;
      gaps_on = 1'b0;
      repeat (40) push(OP_DATA, 8'($urandom), 8'($urandom), pick_pixel());
      gaps_on = 1'b1;

      while (beats_used < RAND_BEATS) begin
         if (beats_used > RAND_BEATS - CALM_TAIL) begin
            gaps_on = 1'b0;
            stalls_on <= 1'b0;
         end
         settle();
         case ($urandom_range(0, 9))
            6: m = MODE_SPARE;
            7: m = MODE_COLOR;
            8: m = MODE_MASKED;
            default: m = MODE_MONO;
         endcase
         rb = ROW_BYTES_W'($urandom_range(0, 15));
         while (!sb.width_allowed(rb)) rb = ROW_BYTES_W'($urandom_range(0, 15));
         configure(m, rb);
         if (m == MODE_COLOR || m == MODE_MASKED) color_phase($urandom_range(10, 40));
         else mono_phase($urandom_range(20, 80));
      end

      settle();
      if (sb.pending_groups.size() != 0)
         sb.report($sformatf("%0d groups never returned", sb.pending_groups.size()));
      if (sb.errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/cmta_pkg.sv
hw/rtl/cmta_sequencer.sv
hw/rtl/cmta_line_mem.sv
hw/rtl/cmta_emit.sv
hw/rtl/cursor_mask_to_argb_unit.sv
dv/tb.sv
